// ----- rtl/srx_pkg.sv -----
package srx_pkg;

   localparam int BLOCK_BYTES   = 131;
   localparam int PAYLOAD_BYTES = 128;
   localparam int HOLD_LIMIT    = 1024;
   localparam int QUEUE_DEPTH   = 4;

   localparam int PTR_W   = $clog2(BLOCK_BYTES);
   localparam int PAY_W   = $clog2(PAYLOAD_BYTES);
   localparam int HELD_W  = $clog2(HOLD_LIMIT);
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam int TICK_W  = 16;
   localparam int POS_W   = 18;
   localparam int ADDR_W  = 16;
   localparam int WORD_W  = 64;
   localparam int KIND_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_FIELD_W = POS_W + WORD_W + ADDR_W + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [POS_W-1:0]  IMAGE_BASE   = 18'h000D0;
   localparam logic [POS_W-1:0]  BANK_OFFSET  = 18'h0FFFF;
   localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;

   localparam logic [TICK_W-1:0] GAP_RESET    = 16'd2;
   localparam logic [TICK_W-1:0] FINISH_RESET = 16'd100;
   localparam logic [POS_W-1:0]  IMAGE_RESET  = 18'h180D0;

   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINISH_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_SIZE   = 2'd2;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE    = 3'd0,
      KIND_NACK     = 3'd1,
      KIND_ACK      = 3'd2,
      KIND_FINISHED = 3'd3,
      KIND_OVERFLOW = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      OP_BYTE,
      OP_OVERFLOW,
      OP_BLOCK,
      OP_ACK,
      OP_FINISH
   } queue_op_type;

   typedef struct packed {
      queue_op_type          op;
      logic [7:0]            data;
   } queue_entry_type;

   typedef struct packed {
      logic [TICK_W-1:0] gap_ticks;
      logic [TICK_W-1:0] finish_ticks;
      logic [POS_W-1:0]  image_size;
   } cfg_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SUM,
      BK_SUM_DRAIN,
      BK_EVAL,
      BK_FIT,
      BK_GATHER,
      BK_GATHER_DRAIN,
      BK_EMIT,
      BK_NACK,
      BK_ACK,
      BK_FINISH,
      BK_OVERFLOW
   } back_state_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(BLOCK_BYTES - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage

// ----- rtl/serial_block_receiver_unit.sv -----
// A received byte goes through the queue into the window while the back end is idle; an ACK,
// overflow or finished transaction leaves the output register after its item has passed the
// queue and the back-end state. A block holds the back end while it reads and checks the window
// through its single read port, then emits eight-byte writes if it fits the image and an ACK,
// after a NACK on a bad sum. Throughput: one item per cycle while the four-entry queue has room.
// Reset is synchronous and clears counters, pointers, queue and output; the window is not cleared.
module serial_block_receiver_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srx_pkg::REQ_DATA_W-1:0] req_tdata,  // rx_byte
   input  logic                           req_tuser,  // cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // position, payload_word, block_address, address_unexpected, zero fill
   output logic [srx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [srx_pkg::KIND_W-1:0]     rsp_tuser,  // kind
   output logic                           rsp_tlast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [srx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srx_pkg::CSR_DATA_W-1:0] csr_wdata
);

   srx_pkg::cfg_type         cfg_ff;
   logic                     q_full;
   logic                     q_push;
   srx_pkg::queue_entry_type q_entry;
   logic                     q_pop;
   logic                     head_valid;
   srx_pkg::queue_entry_type head_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_ticks    <= srx_pkg::GAP_RESET;
         cfg_ff.finish_ticks <= srx_pkg::FINISH_RESET;
         cfg_ff.image_size   <= srx_pkg::IMAGE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            srx_pkg::CSR_GAP_TICKS:    cfg_ff.gap_ticks    <= csr_wdata[15:0];
            srx_pkg::CSR_FINISH_TICKS: cfg_ff.finish_ticks <= csr_wdata[15:0];
            srx_pkg::CSR_IMAGE_SIZE:   cfg_ff.image_size   <= csr_wdata[17:0];
            default: begin
            end
         endcase
      end
   end

   srx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   srx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   srx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/srx_queue.sv -----
module srx_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  srx_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output srx_pkg::queue_entry_type head_entry
);

   srx_pkg::queue_entry_type entry_ff [srx_pkg::QUEUE_DEPTH];
   logic [srx_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [srx_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [srx_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   function automatic logic [srx_pkg::QPTR_W-1:0] qinc(input logic [srx_pkg::QPTR_W-1:0] p);
      logic [srx_pkg::QPTR_W-1:0] r;
      if (p == srx_pkg::QPTR_W'(srx_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + srx_pkg::QPTR_W'(1);
      end
      return r;
   endfunction

   assign full       = (count_ff == srx_pkg::QCNT_W'(srx_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? qinc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? qinc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + srx_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - srx_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/srx_front.sv -----
module srx_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srx_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  srx_pkg::cfg_type               cfg,
   input  logic                           q_full,
   output logic                           q_push,
   output srx_pkg::queue_entry_type       q_entry
);

   logic [srx_pkg::TICK_W-1:0] idle_ff, idle_in;
   logic [srx_pkg::HELD_W-1:0] held_ff, held_in;
   logic                       seen_ff, seen_in;
   logic                       done_ff, done_in;
   logic                       accept;
   logic [srx_pkg::HELD_W:0]   held_inc;
   logic [srx_pkg::TICK_W-1:0] idle_next;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign held_inc   = {1'b0, held_ff} + (srx_pkg::HELD_W + 1)'(1);
   assign idle_next  = (idle_ff == srx_pkg::TICK_MAX) ? idle_ff
                                                      : idle_ff + srx_pkg::TICK_W'(1);

   always_comb begin
      idle_in      = idle_ff;
      held_in      = held_ff;
      seen_in      = seen_ff;
      done_in      = done_ff;
      q_push       = 1'b0;
      q_entry.op   = srx_pkg::OP_BYTE;
      q_entry.data = req_tdata;
      if (accept && !done_ff) begin
         if (req_tuser == srx_pkg::CMD_BYTE) begin
            idle_in = '0;
            q_push  = 1'b1;
            if (int'(held_inc) >= srx_pkg::HOLD_LIMIT) begin
               held_in    = '0;
               q_entry.op = srx_pkg::OP_OVERFLOW;
            end else begin
               held_in = held_inc[srx_pkg::HELD_W-1:0];
            end
         end else begin
            idle_in = idle_next;
            if (idle_next > cfg.gap_ticks) begin
               if (int'(held_ff) >= srx_pkg::BLOCK_BYTES) begin
                  q_push     = 1'b1;
                  q_entry.op = srx_pkg::OP_BLOCK;
                  seen_in    = 1'b1;
                  held_in    = '0;
               end else if (held_ff != '0) begin
                  q_push     = 1'b1;
                  q_entry.op = srx_pkg::OP_ACK;
                  held_in    = '0;
               end else if (seen_ff && (idle_next > cfg.finish_ticks)) begin
                  q_push     = 1'b1;
                  q_entry.op = srx_pkg::OP_FINISH;
                  done_in    = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= '0;
         held_ff <= '0;
         seen_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         idle_ff <= idle_in;
         held_ff <= held_in;
         seen_ff <= seen_in;
         done_ff <= done_in;
      end
   end

endmodule

// ----- rtl/srx_back.sv -----
module srx_back (
   input  logic                           clock,
   input  logic                           reset,
   input  srx_pkg::cfg_type               cfg,
   input  logic                           head_valid,
   input  srx_pkg::queue_entry_type       head_entry,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [srx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [srx_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                           rsp_tlast
);

   localparam int PTR_W = srx_pkg::PTR_W;
   localparam int PAY_W = srx_pkg::PAY_W;
   localparam int POS_W = srx_pkg::POS_W;
   localparam int ADDR_W = srx_pkg::ADDR_W;
   localparam int WORD_W = srx_pkg::WORD_W;

   logic [7:0] win_mem [srx_pkg::BLOCK_BYTES];

   srx_pkg::back_state_type state_ff, state_in;

   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  k_ff;
   logic [PAY_W-1:0]  pay_idx_ff;
   logic [2:0]        j_ff;
   logic              pay_end_ff;
   logic [7:0]        rd_data_ff;
   logic              rd_valid_ff;
   logic              rd_pay_ff;
   logic [PTR_W-1:0]  rd_k_ff;
   logic [2:0]        rd_j_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]        sum_ff;
   logic [7:0]        chk_ff;
   logic              unexp_ff;
   logic [ADDR_W-1:0] prev_ff;
   logic              bank_ff;
   logic              seen_ff;
   logic              good_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [WORD_W-1:0] word_ff;

   logic                      rsp_valid_ff;
   srx_pkg::kind_type         rsp_kind_ff;
   logic [POS_W-1:0]          rsp_pos_ff;
   logic [WORD_W-1:0]         rsp_word_ff;
   logic [ADDR_W-1:0]         rsp_addr_ff;
   logic                      rsp_unexp_ff;
   logic                      rsp_last_ff;

   logic              out_free;
   logic              mem_we;
   logic              issue;
   logic              load;
   srx_pkg::kind_type load_kind;
   logic              load_last;
   logic              load_data;
   logic              load_addr;
   logic              fits;
   logic              bank_new;
   logic              pay_last;
   logic [PTR_W:0]    ptr_plus2;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign fits      = ({1'b0, pos_ff} + (POS_W + 1)'(srx_pkg::PAYLOAD_BYTES))
                      < {1'b0, cfg.image_size};
   assign bank_new  = bank_ff || (seen_ff && (addr_ff == '0));
   assign pay_last  = (pay_idx_ff == PAY_W'(srx_pkg::PAYLOAD_BYTES - 1));
   assign ptr_plus2 = {1'b0, wr_ptr_ff} + (PTR_W + 1)'(2);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srx_pkg::BK_IDLE: begin
            if (head_valid) begin
               unique case (head_entry.op)
                  srx_pkg::OP_BYTE:     state_in = srx_pkg::BK_IDLE;
                  srx_pkg::OP_OVERFLOW: state_in = srx_pkg::BK_OVERFLOW;
                  srx_pkg::OP_BLOCK:    state_in = srx_pkg::BK_SUM;
                  srx_pkg::OP_ACK:      state_in = srx_pkg::BK_ACK;
                  srx_pkg::OP_FINISH:   state_in = srx_pkg::BK_FINISH;
                  default:              state_in = srx_pkg::BK_IDLE;
               endcase
            end
         end
         srx_pkg::BK_SUM: begin
            if (k_ff == PTR_W'(srx_pkg::BLOCK_BYTES - 1)) begin
               state_in = srx_pkg::BK_SUM_DRAIN;
            end
         end
         srx_pkg::BK_SUM_DRAIN: state_in = srx_pkg::BK_EVAL;
         srx_pkg::BK_EVAL:      state_in = srx_pkg::BK_FIT;
         srx_pkg::BK_FIT: begin
            if (!good_ff) begin
               state_in = srx_pkg::BK_NACK;
            end else if (fits) begin
               state_in = srx_pkg::BK_GATHER;
            end else begin
               state_in = srx_pkg::BK_ACK;
            end
         end
         srx_pkg::BK_GATHER: begin
            if ((j_ff == 3'd7) || pay_last) begin
               state_in = srx_pkg::BK_GATHER_DRAIN;
            end
         end
         srx_pkg::BK_GATHER_DRAIN: state_in = srx_pkg::BK_EMIT;
         srx_pkg::BK_EMIT: begin
            if (out_free) begin
               state_in = pay_end_ff ? srx_pkg::BK_ACK : srx_pkg::BK_GATHER;
            end
         end
         srx_pkg::BK_NACK: begin
            if (out_free) begin
               state_in = srx_pkg::BK_ACK;
            end
         end
         srx_pkg::BK_ACK, srx_pkg::BK_FINISH, srx_pkg::BK_OVERFLOW: begin
            if (out_free) begin
               state_in = srx_pkg::BK_IDLE;
            end
         end
         default: state_in = srx_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      issue     = 1'b0;
      load      = 1'b0;
      pop       = 1'b0;
      load_kind = srx_pkg::KIND_ACK;
      load_last = 1'b0;
      load_data = 1'b0;
      load_addr = 1'b0;
      unique case (state_ff)
         srx_pkg::BK_IDLE: begin
            if (head_valid && ((head_entry.op == srx_pkg::OP_BYTE) ||
                               (head_entry.op == srx_pkg::OP_OVERFLOW))) begin
               mem_we = 1'b1;
            end
            pop = head_valid && (head_entry.op == srx_pkg::OP_BYTE);
         end
         srx_pkg::BK_SUM, srx_pkg::BK_GATHER: issue = 1'b1;
         srx_pkg::BK_EMIT: begin
            load      = out_free;
            load_kind = srx_pkg::KIND_WRITE;
            load_data = 1'b1;
            load_addr = 1'b1;
         end
         srx_pkg::BK_NACK: begin
            load      = out_free;
            load_kind = srx_pkg::KIND_NACK;
            load_addr = 1'b1;
         end
         srx_pkg::BK_ACK: begin
            load      = out_free;
            pop       = out_free;
            load_kind = srx_pkg::KIND_ACK;
            load_last = 1'b1;
            load_addr = 1'b1;
         end
         srx_pkg::BK_FINISH: begin
            load      = out_free;
            pop       = out_free;
            load_kind = srx_pkg::KIND_FINISHED;
            load_last = 1'b1;
         end
         srx_pkg::BK_OVERFLOW: begin
            load      = out_free;
            pop       = out_free;
            load_kind = srx_pkg::KIND_OVERFLOW;
            load_last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[wr_ptr_ff] <= head_entry.data;
      end
      rd_data_ff <= win_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srx_pkg::BK_IDLE;
         wr_ptr_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         prev_ff      <= '0;
         bank_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
         if (mem_we) begin
            wr_ptr_ff <= srx_pkg::ptr_inc(wr_ptr_ff);
         end
         if (state_ff == srx_pkg::BK_EVAL) begin
            prev_ff <= addr_ff;
            bank_ff <= bank_new;
            seen_ff <= 1'b1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_pay_ff <= (state_ff == srx_pkg::BK_GATHER);
      rd_k_ff   <= k_ff;
      rd_j_ff   <= j_ff;

      if (state_ff == srx_pkg::BK_IDLE) begin
         rd_ptr_ff <= wr_ptr_ff;
         k_ff      <= '0;
         sum_ff    <= '0;
         addr_ff   <= '0;
         unexp_ff  <= 1'b0;
      end
      if (issue) begin
         rd_ptr_ff <= srx_pkg::ptr_inc(rd_ptr_ff);
      end
      if (state_ff == srx_pkg::BK_SUM) begin
         k_ff <= k_ff + PTR_W'(1);
      end
      if (state_ff == srx_pkg::BK_GATHER) begin
         pay_idx_ff <= pay_idx_ff + PAY_W'(1);
         j_ff       <= j_ff + 3'd1;
         pay_end_ff <= pay_last;
      end

      if (rd_valid_ff) begin
         if (rd_pay_ff) begin
            word_ff[{rd_j_ff, 3'b000} +: 8] <= rd_data_ff;
         end else begin
            if (rd_k_ff == PTR_W'(0)) begin
               addr_ff[15:8] <= rd_data_ff;
            end
            if (rd_k_ff == PTR_W'(1)) begin
               addr_ff[7:0] <= rd_data_ff;
            end
            if (rd_k_ff == PTR_W'(srx_pkg::BLOCK_BYTES - 1)) begin
               chk_ff <= rd_data_ff;
            end else begin
               sum_ff <= sum_ff + rd_data_ff;
            end
         end
      end

      if (state_ff == srx_pkg::BK_EVAL) begin
         unexp_ff <= (addr_ff != '0) &&
                     ({1'b0, addr_ff} != ({1'b0, prev_ff} +
                                          (ADDR_W + 1)'(srx_pkg::PAYLOAD_BYTES)));
         good_ff  <= (sum_ff == chk_ff);
         pos_ff   <= srx_pkg::IMAGE_BASE + POS_W'(addr_ff) +
                     (bank_new ? srx_pkg::BANK_OFFSET : POS_W'(0));
      end
      if (state_ff == srx_pkg::BK_FIT) begin
         rd_ptr_ff  <= (ptr_plus2 >= (PTR_W + 1)'(srx_pkg::BLOCK_BYTES))
                       ? PTR_W'(ptr_plus2 - (PTR_W + 1)'(srx_pkg::BLOCK_BYTES))
                       : ptr_plus2[PTR_W-1:0];
         pay_idx_ff <= '0;
         j_ff       <= '0;
         pay_end_ff <= 1'b0;
         word_ff    <= '0;
      end
      if ((state_ff == srx_pkg::BK_EMIT) && out_free) begin
         pos_ff  <= pos_ff + POS_W'(8);
         word_ff <= '0;
         j_ff    <= '0;
      end

      if (load) begin
         rsp_kind_ff  <= load_kind;
         rsp_last_ff  <= load_last;
         rsp_pos_ff   <= load_data ? pos_ff : '0;
         rsp_word_ff  <= load_data ? word_ff : '0;
         rsp_addr_ff  <= load_addr ? addr_ff : '0;
         rsp_unexp_ff <= load_addr ? unexp_ff : 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(srx_pkg::RSP_DATA_W - srx_pkg::RSP_FIELD_W)'(0),
                        rsp_unexp_ff, rsp_addr_ff, rsp_word_ff, rsp_pos_ff};

endmodule

// ----- rtl/srx_checker.sv -----
module srx_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [srx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [srx_pkg::KIND_W-1:0]     rsp_tuser,
   input logic                           rsp_tlast
);

   localparam int LOW_W = srx_pkg::POS_W + srx_pkg::WORD_W;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("Stalled response transaction changed.");

   a_write_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == srx_pkg::KIND_WRITE) |-> !rsp_tlast)
      else $error("Payload write marked as last.");

   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != srx_pkg::KIND_WRITE) |-> (rsp_tdata[LOW_W-1:0] == '0))
      else $error("Status transaction carries position or payload.");

   a_notice_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == srx_pkg::KIND_FINISHED) ||
                     (rsp_tuser == srx_pkg::KIND_OVERFLOW) ||
                     (rsp_tuser == srx_pkg::KIND_ACK)) |-> rsp_tlast)
      else $error("Closing transaction not marked as last.");

endmodule

bind serial_block_receiver_unit srx_checker u_srx_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
